/* rtl/lge_pkg.sv */
// shared constants, codes and controller/datapath types for the life grid engine
package lge_pkg;

  localparam int ROWS   = 34;
  localparam int COLS   = 48;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int STEP_W = $clog2(ROWS + 2);
  localparam int ACT_W  = 3;
  localparam int ADDR_W = 6;
  localparam int GEN_W  = 32;
  localparam int RNG_W  = 32;

  localparam logic [RNG_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [RNG_W-1:0] LCG_INC = 32'd12345;

  typedef enum logic [ACT_W-1:0] {
    ACT_STEP   = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_RAND   = 3'd2,
    ACT_TOGGLE = 3'd3,
    ACT_PAINT  = 3'd4
  } lge_action_t;

  typedef struct packed {
    logic              take_in;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              rd_item;
    logic              win_clr;
    logic              win_shift;
    logic              win_zero;
    logic              life_wr;
    logic              rand_step;
    logic              rand_wr;
    logic              cell_wr;
    logic [ROW_W-1:0]  wr_addr;
    logic              grid_clr;
    logic              gen_clr;
    logic              gen_inc;
    logic              out_load;
  } lge_cmd_t;

  typedef struct packed {
    lge_action_t action;
    logic        in_grid;
  } lge_sts_t;

endpackage

/* rtl/lge_in_if.sv */
// input item channel: valid/ready with action and cell address
interface lge_in_if
  import lge_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ADDR_W-1:0] row;
  logic [ADDR_W-1:0] col;

  modport source (output valid, output action, output row, output col, input ready);
  modport sink   (input valid, input action, input row, input col, output ready);
endinterface

/* rtl/lge_out_if.sv */
// result item channel: valid/ready with generation count and cell state
interface lge_out_if
  import lge_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [GEN_W-1:0] generation;
  logic             cell_alive;

  modport source (output valid, output generation, output cell_alive, input ready);
  modport sink   (input valid, input generation, input cell_alive, output ready);
endinterface

/* rtl/lge_dp.sv */
// datapath: grid row memory, life row logic, generator, counters and result registers
module lge_dp
  import lge_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lge_cmd_t          cmd,
  output lge_sts_t          sts,
  input  logic [ACT_W-1:0]  item_action,
  input  logic [ADDR_W-1:0] item_row,
  input  logic [ADDR_W-1:0] item_col,
  input  logic              cfg_we,
  input  logic [RNG_W-1:0]  cfg_wdata,
  output logic [GEN_W-1:0]  out_gen,
  output logic              out_cell
);

  logic [COLS-1:0]   mem [ROWS];
  logic [ROWS-1:0]   vld;
  logic [COLS-1:0]   rd_q;
  logic              rd_v;
  logic [COLS-1:0]   rd_eff;

  logic [ACT_W-1:0]  act_q;
  logic [ADDR_W-1:0] row_q;
  logic [ADDR_W-1:0] col_q;
  logic              in_grid;
  logic [ROW_W-1:0]  row_i;
  logic [COL_W-1:0]  col_i;

  logic [COLS-1:0]   prev_row;
  logic [COLS-1:0]   cur_row;
  logic [COLS-1:0]   incoming;
  logic [COLS-1:0]   life_row;

  logic [RNG_W-1:0]  rng;
  logic [RNG_W-1:0]  rng_next;
  logic              rand_bit;
  logic [COLS-1:0]   rand_buf;
  logic [COLS-1:0]   rand_row;

  logic [COLS-1:0]   cell_row;
  logic [GEN_W-1:0]  gen_count;

  logic              rd_fire;
  logic [ROW_W-1:0]  rd_addr;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr;
  logic [COLS-1:0]   wr_data;

  assign in_grid = (7'(row_q) < 7'(ROWS)) && (7'(col_q) < 7'(COLS));
  assign row_i   = row_q[ROW_W-1:0];
  assign col_i   = col_q[COL_W-1:0];
  assign sts.action  = lge_action_t'(act_q);
  assign sts.in_grid = in_grid;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      act_q <= item_action;
      row_q <= item_row;
      col_q <= item_col;
    end
  end

  assign rd_eff   = rd_v ? rd_q : '0;
  assign incoming = cmd.win_zero ? '0 : rd_eff;

  // b3/s23 on one row with dead cells beyond the edges
  always_comb begin
    logic [COLS+1:0] pe;
    logic [COLS+1:0] ue;
    logic [COLS+1:0] ne;
    logic [3:0]      n;
    pe = {1'b0, prev_row, 1'b0};
    ue = {1'b0, cur_row, 1'b0};
    ne = {1'b0, incoming, 1'b0};
    life_row = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 4'(pe[c]) + 4'(pe[c+1]) + 4'(pe[c+2]) + 4'(ue[c]) + 4'(ue[c+2])
        + 4'(ne[c]) + 4'(ne[c+1]) + 4'(ne[c+2]);
      life_row[c] = (n == 4'd3) || ((n == 4'd2) && ue[c+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_clr) begin
      prev_row <= '0;
      cur_row  <= '0;
    end else if (cmd.win_shift) begin
      prev_row <= cur_row;
      cur_row  <= incoming;
    end
  end

  assign rng_next = rng * LCG_MUL + LCG_INC;
  assign rand_bit = (rng_next[17:16] == 2'b00);
  assign rand_row = {rand_bit, rand_buf[COLS-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rng <= RNG_W'(1);
    end else if (cfg_we) begin
      rng <= cfg_wdata | RNG_W'(1);
    end else if (cmd.rand_step) begin
      rng <= rng_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rand_step) begin
      rand_buf <= rand_row;
    end
  end

  always_comb begin
    cell_row = rd_eff;
    if (lge_action_t'(act_q) == ACT_TOGGLE) begin
      cell_row[col_i] = ~rd_eff[col_i];
    end else begin
      cell_row[col_i] = 1'b1;
    end
  end

  assign rd_fire = cmd.rd_en || (cmd.rd_item && in_grid);
  assign rd_addr = cmd.rd_item ? row_i : cmd.rd_addr;
  assign wr_en   = cmd.life_wr || cmd.rand_wr || cmd.cell_wr;
  assign wr_addr = cmd.cell_wr ? row_i : cmd.wr_addr;

  always_comb begin
    if (cmd.life_wr) begin
      wr_data = life_row;
    end else if (cmd.rand_wr) begin
      wr_data = rand_row;
    end else begin
      wr_data = cell_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_fire) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rd_v <= 1'b0;
    end else begin
      if (cmd.grid_clr) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_fire) begin
        rd_v <= vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_count <= '0;
    end else if (cmd.gen_clr) begin
      gen_count <= '0;
    end else if (cmd.gen_inc) begin
      gen_count <= gen_count + GEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_gen  <= gen_count;
      out_cell <= in_grid && rd_eff[col_i];
    end
  end

endmodule

/* rtl/lge_ctrl.sv */
// controller: sequences step, clear, randomize, cell edits and readback for each item
module lge_ctrl
  import lge_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  lge_sts_t sts,
  output lge_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_STEP,
    S_RAND,
    S_CELL_RD,
    S_CELL_WR,
    S_RB_RD,
    S_RB_LATCH
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] j;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic              step_last;
  logic              col_last;
  logic              row_last;
  logic              can_load;

  assign in_ready  = (state == S_IDLE);
  assign step_last = (j == STEP_W'(ROWS + 1));
  assign col_last  = (c == COL_W'(COLS - 1));
  assign row_last  = (r == ROW_W'(ROWS - 1));
  assign can_load  = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.take_in = in_valid;
      end
      S_DECODE: begin
        case (sts.action)
          ACT_STEP:  cmd.win_clr = 1'b1;
          ACT_CLEAR: begin
            cmd.grid_clr = 1'b1;
            cmd.gen_clr  = 1'b1;
          end
          ACT_RAND:  cmd.gen_clr = 1'b1;
          default:   ;
        endcase
      end
      S_STEP: begin
        cmd.rd_en     = (j < STEP_W'(ROWS));
        cmd.rd_addr   = j[ROW_W-1:0];
        cmd.win_shift = (j != '0);
        cmd.win_zero  = step_last;
        cmd.life_wr   = (j >= STEP_W'(2));
        cmd.wr_addr   = ROW_W'(j - STEP_W'(2));
        cmd.gen_inc   = step_last;
      end
      S_RAND: begin
        cmd.rand_step = 1'b1;
        cmd.rand_wr   = col_last;
        cmd.wr_addr   = r;
      end
      S_CELL_RD: cmd.rd_item = 1'b1;
      S_CELL_WR: cmd.cell_wr = 1'b1;
      S_RB_RD:   cmd.rd_item = 1'b1;
      S_RB_LATCH: cmd.out_load = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      j         <= '0;
      r         <= '0;
      c         <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          j <= '0;
          r <= '0;
          c <= '0;
          case (sts.action)
            ACT_STEP:   state <= S_STEP;
            ACT_RAND:   state <= S_RAND;
            ACT_TOGGLE: state <= sts.in_grid ? S_CELL_RD : S_RB_RD;
            ACT_PAINT:  state <= sts.in_grid ? S_CELL_RD : S_RB_RD;
            default:    state <= S_RB_RD;
          endcase
        end
        S_STEP: begin
          j <= j + STEP_W'(1);
          if (step_last) begin
            state <= S_RB_RD;
          end
        end
        S_RAND: begin
          if (col_last) begin
            c <= '0;
            r <= r + ROW_W'(1);
            if (row_last) begin
              state <= S_RB_RD;
            end
          end else begin
            c <= c + COL_W'(1);
          end
        end
        S_CELL_RD:  state <= S_CELL_WR;
        S_CELL_WR:  state <= S_RB_RD;
        S_RB_RD:    state <= S_RB_LATCH;
        S_RB_LATCH: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/life_grid_engine.sv */
// life grid engine top level: b3/s23 grid with clear, randomize and cell edits
// step: one grid row per cycle through the window
// randomize: one generator multiply per cell
// toggle and paint: read-modify-write of one row
// one item at a time; the next item is taken in the cycle after the result is loaded, even if it waits
// reset: grid reads all dead through per-row valid bits, generation 0, generator state 1
module life_grid_engine
  import lge_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  lge_in_if.sink           item,
  lge_out_if.source        result,
  input  logic             cfg_we,
  input  logic [RNG_W-1:0] cfg_wdata
);

  lge_cmd_t         cmd;
  lge_sts_t         sts;
  logic [GEN_W-1:0] out_gen;
  logic             out_cell;
  logic             out_valid;
  logic             in_ready;

  lge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lge_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .item_action (item.action),
    .item_row    (item.row),
    .item_col    (item.col),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_gen     (out_gen),
    .out_cell    (out_cell)
  );

  assign item.ready        = in_ready;
  assign result.valid      = out_valid;
  assign result.generation = out_gen;
  assign result.cell_alive = out_cell;

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("second item taken while one is in progress");

  a_life_row: assert property (@(posedge clk) disable iff (rst)
    cmd.life_wr |-> (int'(cmd.wr_addr) < ROWS))
    else $error("life row write beyond grid");

  a_cell_in_grid: assert property (@(posedge clk) disable iff (rst)
    cmd.cell_wr |-> sts.in_grid)
    else $error("cell write for address outside grid");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result.valid || result.ready))
    else $error("result register overwritten before taken");

endmodule
